FILE: rtl/core/c2d_pkg.sv
// Shared types and constants for the 2D convolution block.
package c2d_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_KERNEL = 2'd0,
    OP_LOAD_IMAGE  = 2'd1,
    OP_READ        = 2'd2,
    OP_NONE        = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CROP_FULL  = 2'd0,
    CROP_SAME  = 2'd1,
    CROP_VALID = 2'd2,
    CROP_RSVD  = 2'd3
  } crop_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_ROWS  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_COLS  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KERNEL_ROWS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KERNEL_COLS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CROP_MODE   = 3'd4;
  localparam int unsigned CfgDataW = 7;

  localparam int unsigned AccW = 40;
  localparam int unsigned PosW = 7;

  // controller -> datapath
  typedef struct packed {
    logic clear;     // start of a read: zero accumulator
    logic mac;       // accumulate the registered product of a tap fetched earlier
    logic fetch;     // issue store reads for the current tap
  } dp_cmd_t;

endpackage

FILE: rtl/core/c2d_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface c2d_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] sample_value;
  modport source (output valid, opcode, sample_value, input ready);
  modport sink (input valid, opcode, sample_value, output ready);
endinterface

interface c2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] result_value;
  logic [6:0]         out_row;
  logic [6:0]         out_col;
  logic               last_element;
  logic               status;
  modport source (output valid, result_value, out_row, out_col, last_element, status,
                  input ready);
  modport sink (input valid, result_value, out_row, out_col, last_element, status,
                output ready);
endinterface

FILE: rtl/core/c2d_datapath.sv
// Sample stores and multiply-accumulate datapath.
module c2d_datapath import c2d_pkg::*; #(
  parameter int unsigned ImgDepth = 4096,
  parameter int unsigned KerDepth = 64,
  parameter int unsigned SampleW  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        img_we_i,
  input  logic [$clog2(ImgDepth)-1:0] img_waddr_i,
  input  logic                        ker_we_i,
  input  logic [$clog2(KerDepth)-1:0] ker_waddr_i,
  input  logic signed [SampleW-1:0]   wdata_i,
  input  logic [$clog2(ImgDepth)-1:0] img_raddr_i,
  input  logic [$clog2(KerDepth)-1:0] ker_raddr_i,
  input  dp_cmd_t                     cmd_i,
  output logic signed [AccW-1:0]      acc_o
);

  logic signed [SampleW-1:0] img_mem [ImgDepth];
  logic signed [SampleW-1:0] ker_mem [KerDepth];
  logic signed [SampleW-1:0] img_rd_q, ker_rd_q;
  logic signed [2*SampleW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0] acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (img_we_i) img_mem[img_waddr_i] <= wdata_i;
    if (ker_we_i) ker_mem[ker_waddr_i] <= wdata_i;
    if (cmd_i.fetch) begin
      img_rd_q <= img_mem[img_raddr_i];
      ker_rd_q <= ker_mem[ker_raddr_i];
    end
  end

  assign prod_d = img_rd_q * ker_rd_q;

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.clear) acc_d = '0;
    else if (cmd_i.mac) acc_d = acc_q + AccW'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      prod_q <= '0;
    end else begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/core/c2d_ctrl.sv
// Controller: load indexing, read position and tap sequencing.
module c2d_ctrl import c2d_pkg::*; #(
  parameter int unsigned MaxIr = 64,
  parameter int unsigned MaxIc = 64,
  parameter int unsigned MaxKr = 8,
  parameter int unsigned MaxKc = 8,
  parameter int unsigned SampleW = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  c2d_in_if.sink                   in_if,
  c2d_out_if.source                out_if,
  output logic                     img_we_o,
  output logic [$clog2(MaxIr*MaxIc)-1:0] img_waddr_o,
  output logic                     ker_we_o,
  output logic [$clog2(MaxKr*MaxKc)-1:0] ker_waddr_o,
  output logic signed [SampleW-1:0] wdata_o,
  output logic [$clog2(MaxIr*MaxIc)-1:0] img_raddr_o,
  output logic [$clog2(MaxKr*MaxKc)-1:0] ker_raddr_o,
  output dp_cmd_t                  cmd_o,
  input  logic signed [AccW-1:0]   acc_i
);

  localparam int unsigned ImgA = $clog2(MaxIr*MaxIc);
  localparam int unsigned KerA = $clog2(MaxKr*MaxKc);
  localparam int unsigned DW = 12; // holds sizes up to 2*MaxIr and products of positions

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_RUN, S_DRAIN1, S_DRAIN2, S_OUT} state_e;

  state_e state_q;
  logic [6:0] ir_q, ic_q;
  logic [3:0] kr_q, kc_q;
  crop_e      crop_q;
  logic [ImgA-1:0] img_li_q;
  logic [KerA-1:0] ker_li_q;
  logic [PosW-1:0] rrow_q, rcol_q;
  logic            done_q;
  logic [3:0]      m_q, n_q;
  logic [DW-1:0]   p_q, q_q;
  logic            fetch_q, mac_q;
  logic            ovalid_q, ostat_q, olast_q;
  logic signed [AccW-1:0] ores_q;
  logic [PosW-1:0] orow_q, ocol_q;

  function automatic logic [6:0] clamp7(input logic [6:0] v, input int unsigned mx);
    if (v == '0) return 7'd1;
    if (32'(v) > mx) return 7'(mx);
    return v;
  endfunction
  function automatic logic [3:0] clamp4(input logic [3:0] v, input int unsigned mx);
    if (v == '0) return 4'd1;
    if (32'(v) > mx) return 4'(mx);
    return v;
  endfunction

  // output geometry
  logic [DW-1:0] orows, ocols, dr, dc;
  logic          geo_ok;
  always_comb begin
    geo_ok = 1'b1;
    unique case (crop_q)
      CROP_SAME: begin
        dr = DW'(kr_q >> 1); dc = DW'(kc_q >> 1); orows = DW'(ir_q); ocols = DW'(ic_q);
      end
      CROP_VALID: begin
        dr = DW'(kr_q) - 1'b1; dc = DW'(kc_q) - 1'b1;
        if (DW'(kr_q) > DW'(ir_q) || DW'(kc_q) > DW'(ic_q)) begin
          geo_ok = 1'b0; orows = '0; ocols = '0;
        end else begin
          orows = DW'(ir_q) - DW'(kr_q) + 1'b1; ocols = DW'(ic_q) - DW'(kc_q) + 1'b1;
        end
      end
      default: begin
        dr = '0; dc = '0;
        orows = DW'(ir_q) + DW'(kr_q) - 1'b1; ocols = DW'(ic_q) + DW'(kc_q) - 1'b1;
      end
    endcase
  end

  logic [ImgA:0] img_cnt;
  logic [KerA:0] ker_cnt;
  assign img_cnt = (ImgA+1)'(ir_q * ic_q);
  assign ker_cnt = (KerA+1)'(kr_q * kc_q);

  logic [ImgA-1:0] img_slot;
  logic [KerA-1:0] ker_slot;
  assign img_slot = ((ImgA+1)'(img_li_q) < img_cnt) ? img_li_q : '0;
  assign ker_slot = ((KerA+1)'(ker_li_q) < ker_cnt) ? ker_li_q : '0;

  logic in_fire, out_fire, is_read;
  assign in_if.ready = (state_q == S_IDLE) && !ovalid_q;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign is_read  = opcode_e'(in_if.opcode) == OP_READ;

  assign img_we_o    = in_fire && opcode_e'(in_if.opcode) == OP_LOAD_IMAGE;
  assign ker_we_o    = in_fire && opcode_e'(in_if.opcode) == OP_LOAD_KERNEL;
  assign img_waddr_o = img_slot;
  assign ker_waddr_o = ker_slot;
  assign wdata_o     = SampleW'(in_if.sample_value);

  // current tap, in range when p-m and q-n land in the image
  logic [DW-1:0] pi, qi;
  logic          tap_ok;
  assign pi = p_q - DW'(m_q);
  assign qi = q_q - DW'(n_q);
  assign tap_ok = (DW'(m_q) <= p_q) && (pi < DW'(ir_q)) &&
                  (DW'(n_q) <= q_q) && (qi < DW'(ic_q));
  assign img_raddr_o = ImgA'(pi * DW'(ic_q) + qi);
  assign ker_raddr_o = KerA'(m_q * kc_q + n_q);

  assign cmd_o.clear = (state_q == S_SETUP);
  assign cmd_o.fetch = (state_q == S_RUN);
  assign cmd_o.mac   = mac_q;

  logic last_tap;
  assign last_tap = (n_q + 1'b1 == kc_q) && (m_q + 1'b1 == kr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ir_q <= 7'(MaxIr > 64 ? 64 : MaxIr); ic_q <= 7'(MaxIc > 64 ? 64 : MaxIc);
      kr_q <= 4'(MaxKr > 5 ? 5 : MaxKr);   kc_q <= 4'(MaxKc > 5 ? 5 : MaxKc);
      crop_q <= CROP_FULL;
      img_li_q <= '0; ker_li_q <= '0;
      rrow_q <= '0; rcol_q <= '0; done_q <= 1'b0;
      m_q <= '0; n_q <= '0; p_q <= '0; q_q <= '0;
      fetch_q <= 1'b0; mac_q <= 1'b0;
      ovalid_q <= 1'b0; ostat_q <= 1'b0; olast_q <= 1'b0;
      ores_q <= '0; orow_q <= '0; ocol_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IMAGE_ROWS:  ir_q <= clamp7(cfg_data_i, MaxIr);
          REG_IMAGE_COLS:  ic_q <= clamp7(cfg_data_i, MaxIc);
          REG_KERNEL_ROWS: kr_q <= clamp4(cfg_data_i[3:0], MaxKr);
          REG_KERNEL_COLS: kc_q <= clamp4(cfg_data_i[3:0], MaxKc);
          REG_CROP_MODE:   crop_q <= crop_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
      if (out_fire) ovalid_q <= 1'b0;
      mac_q   <= fetch_q;
      fetch_q <= (state_q == S_RUN) && tap_ok;
      unique case (state_q)
        S_IDLE: if (in_fire) begin
          if (ker_we_o)
            ker_li_q <= ((KerA+1)'(ker_slot) + 1'b1 >= ker_cnt) ? '0 : ker_slot + 1'b1;
          if (img_we_o) begin
            img_li_q <= ((ImgA+1)'(img_slot) + 1'b1 >= img_cnt) ? '0 : img_slot + 1'b1;
            rrow_q <= '0; rcol_q <= '0; done_q <= 1'b0;
          end
          if (is_read) begin
            if (!geo_ok || done_q || DW'(rrow_q) >= orows || DW'(rcol_q) >= ocols) begin
              ovalid_q <= 1'b1; ostat_q <= 1'b1; olast_q <= 1'b0;
              ores_q <= '0; orow_q <= '0; ocol_q <= '0;
            end else begin
              p_q <= DW'(rrow_q) + dr; q_q <= DW'(rcol_q) + dc;
              m_q <= '0; n_q <= '0;
              state_q <= S_SETUP;
            end
          end
        end
        S_SETUP: state_q <= S_RUN;
        S_RUN: begin
          if (n_q + 1'b1 == kc_q) begin
            n_q <= '0; m_q <= m_q + 1'b1;
          end else n_q <= n_q + 1'b1;
          if (last_tap) state_q <= S_DRAIN1;
        end
        S_DRAIN1: state_q <= S_DRAIN2;
        S_DRAIN2: state_q <= S_OUT;
        S_OUT: begin
          // accumulator already holds the last tap, added as S_DRAIN2 ends
          ovalid_q <= 1'b1; ostat_q <= 1'b0;
          ores_q <= acc_i; orow_q <= rrow_q; ocol_q <= rcol_q;
          if (DW'(rrow_q) + 1'b1 == orows && DW'(rcol_q) + 1'b1 == ocols) begin
            olast_q <= 1'b1; done_q <= 1'b1;
          end else begin
            olast_q <= 1'b0;
            if (DW'(rcol_q) + 1'b1 >= ocols) begin
              rcol_q <= '0; rrow_q <= rrow_q + 1'b1;
            end else rcol_q <= rcol_q + 1'b1;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid        = ovalid_q;
  assign out_if.result_value = ores_q;
  assign out_if.out_row      = orow_q;
  assign out_if.out_col      = ocol_q;
  assign out_if.last_element = olast_q;
  assign out_if.status       = ostat_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostat_q) |-> (ores_q == '0 && !olast_q)) else $error("error beat not zero");
  a_mac_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_q |-> $past(fetch_q)) else $error("mac without fetch");

endmodule

FILE: rtl/core/conv2d_full_same_valid.sv
// Top level of the 2D convolution block (full/same/valid).
// Load beats (kernel coefficient, image sample) are written into the stores as
// they are taken. A read beat steps through every kernel tap with one
// multiply-accumulate unit, passing S_SETUP, S_RUN, S_DRAIN1, S_DRAIN2 and S_OUT;
// an error read skips these and is answered from idle. The result register
// holds one beat, and input is taken again once that beat is delivered.
module conv2d_full_same_valid import c2d_pkg::*; #(
  parameter int unsigned MAX_IMAGE_ROWS  = 64,
  parameter int unsigned MAX_IMAGE_COLS  = 64,
  parameter int unsigned MAX_KERNEL_ROWS = 8,
  parameter int unsigned MAX_KERNEL_COLS = 8,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  c2d_in_if.sink              in_if,
  c2d_out_if.source           out_if
);

  localparam int unsigned ImgDepth = MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
  localparam int unsigned KerDepth = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;

  logic img_we, ker_we;
  logic [$clog2(ImgDepth)-1:0] img_waddr, img_raddr;
  logic [$clog2(KerDepth)-1:0] ker_waddr, ker_raddr;
  logic signed [SAMPLE_BITS-1:0] wdata;
  dp_cmd_t cmd;
  logic signed [AccW-1:0] acc;

  c2d_ctrl #(
    .MaxIr(MAX_IMAGE_ROWS), .MaxIc(MAX_IMAGE_COLS),
    .MaxKr(MAX_KERNEL_ROWS), .MaxKc(MAX_KERNEL_COLS), .SampleW(SAMPLE_BITS)
  ) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if, .out_if,
    .img_we_o(img_we), .img_waddr_o(img_waddr),
    .ker_we_o(ker_we), .ker_waddr_o(ker_waddr), .wdata_o(wdata),
    .img_raddr_o(img_raddr), .ker_raddr_o(ker_raddr),
    .cmd_o(cmd), .acc_i(acc)
  );

  c2d_datapath #(
    .ImgDepth(ImgDepth), .KerDepth(KerDepth), .SampleW(SAMPLE_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .img_we_i(img_we), .img_waddr_i(img_waddr),
    .ker_we_i(ker_we), .ker_waddr_i(ker_waddr), .wdata_i(wdata),
    .img_raddr_i(img_raddr), .ker_raddr_i(ker_raddr),
    .cmd_i(cmd), .acc_o(acc)
  );

endmodule
